// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the top level and the divider.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
// Implication checked in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rstn, pre, post)
`define ASSERT_NEXT(label, clk, rstn, pre, post)
`endif
`endif

// ----- rtl/kfa_pkg.sv -----
// Package with the types and constants of the keyframe animator.
`timescale 1ns / 1ps
package kfa_pkg;
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_START  = 3'd1;
    localparam logic [2:0] MODE_PAUSE  = 3'd2;
    localparam logic [2:0] MODE_STOP   = 3'd3;
    localparam logic [2:0] MODE_APPEND = 3'd4;

    localparam logic [2:0] REG_DURATION = 3'd0;
    localparam logic [2:0] REG_TICK     = 3'd1;
    localparam logic [2:0] REG_LOOPS    = 3'd2;
    localparam logic [2:0] REG_START    = 3'd3;
    localparam logic [2:0] REG_END      = 3'd4;
    localparam logic [2:0] REG_COLOUR   = 3'd5;

    // Width of start, end, keyframe and result values.
    localparam int          VALUE_BITS  = 32;
    localparam logic [16:0] ONE_Q16     = 17'h10000;
    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_BOUNDS,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL,
        ST_LERP,
        ST_OUT
    } state_t;

    // Divider handshake between the sequencer and the divider.
    typedef struct packed {
        logic        start;
        logic [32:0] num;
        logic [32:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [16:0] quot;
    } div_rsp_t;
endpackage

// ----- rtl/keyframe_animation_interpolator.sv -----
// Top level of the keyframe animator: control sequencer, key store and divider.
//
// Usage: configuration goes through cfg_we / cfg_addr / cfg_wdata while idle.
// Input transactions arrive on s_axis (mode on tuser, key_percent and
// key_value on tdata); a tick while running and every stop give one
// transaction on m_axis (value and segment on tdata, finished on tlast).
// Start, pause, append and unused modes give none.
// A running tick passes from acceptance to m_axis_tvalid through the key store
// read, bounds multiply, the 49-step serial divider for progress, one
// interpolation multiply, then the result register. When the progress needs
// no division (no positive span, or time at or before the segment start) the
// divider is skipped. A stop shows its result in the cycle after acceptance.
// One item is worked at a time; s_axis_tready is low while one is in
// flight or a result waits. When m_axis_tready is low the result is held in
// the output register and no new item is taken. Reset clears the run state,
// the keyframe count and the configuration to their defaults; the key store
// itself is not cleared and only entries below the keyframe count are used.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module keyframe_animation_interpolator #(
    parameter int MAX_KEYS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_addr,
    input  logic [31:0]           cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // mode[2:0]
    input  logic [2:0]            s_axis_tuser,
    // key_percent[15:0], key_value[47:16]
    input  logic [47:0]           s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // value[31:0], segment[35:32], zero fill to 40
    output logic [39:0]           m_axis_tdata,
    output logic                  m_axis_tlast
);
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int VB = kfa_pkg::VALUE_BITS;

    // Configuration registers.
    logic [15:0]   dur_reg;
    logic [7:0]    tick_reg;
    logic [15:0]   loops_reg;
    logic [VB-1:0] sval_reg;
    logic [VB-1:0] eval_reg;
    logic          colour_reg;

    // Run state.
    kfa_pkg::state_t state_reg, state_next;
    logic [CW-1:0] total_reg;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic [16:0]   elapsed_reg, elapsed_next;
    logic [15:0]   done_cnt_reg, done_cnt_next;
    logic          run_reg, run_next;
    logic [CW-1:0] seg_reg;

    // Segment working registers.
    logic [VB-1:0] s_reg, e_reg;
    logic [32:0]   lo_reg, hi_reg;
    logic [16:0]   p_reg;
    logic [39:0]   prod_reg [3];
    logic [VB-1:0] val_reg;
    logic          fin_reg;

    logic [39:0]   out_reg;
    logic          out_last_reg;
    logic          out_valid_reg;

    logic          s_acc;
    logic [2:0]    in_mode;
    logic [15:0]   in_pct;
    logic [VB-1:0] in_val;

    logic [AW-1:0] rd_a, rd_b;
    logic [15:0]   pos_a, pos_b;
    logic [VB-1:0] val_a, val_b;
    logic          key_we;

    kfa_pkg::div_req_t div_req;
    kfa_pkg::div_rsp_t div_rsp;

    assign in_mode = s_axis_tuser;
    assign in_pct  = s_axis_tdata[15:0];
    assign in_val  = s_axis_tdata[16+VB-1:16];
    assign s_axis_tready = (state_reg == kfa_pkg::ST_IDLE) && !out_valid_reg;
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign key_we = s_acc && in_mode == kfa_pkg::MODE_APPEND && in_pct != 16'd0
                    && total_reg < CW'(MAX_KEYS);

    // Cursor capped at the key count; reads fetch both neighbours.
    logic [CW-1:0] cur_c;
    assign cur_c = (cursor_reg > total_reg) ? total_reg : cursor_reg;
    assign rd_a = AW'(cur_c - CW'(1));
    assign rd_b = (cur_c >= CW'(MAX_KEYS)) ? '0 : AW'(cur_c);

    kfa_key_store #(.MAX_KEYS(MAX_KEYS), .VALUE_BITS(VB)) u_store (
        .aclk     (aclk),
        .wr_en    (key_we),
        .wr_addr  (AW'(total_reg)),
        .wr_pos   (in_pct),
        .wr_val   (in_val),
        .rd_addr_a(rd_a),
        .rd_addr_b(rd_b),
        .rd_pos_a (pos_a),
        .rd_val_a (val_a),
        .rd_pos_b (pos_b),
        .rd_val_b (val_b)
    );

    kfa_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    // Progress operands.
    logic [32:0] now_q;
    assign now_q = {elapsed_reg, 16'd0};

    // Divider request: only where the span and start leave a real quotient.
    logic span_ok, past_lo;
    assign span_ok = hi_reg > lo_reg;
    assign past_lo = now_q > lo_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kfa_pkg::ST_IDLE: begin
                if (s_acc && in_mode == kfa_pkg::MODE_TICK && run_reg) begin
                    state_next = kfa_pkg::ST_READ;
                end
            end
            kfa_pkg::ST_READ:      state_next = kfa_pkg::ST_BOUNDS;
            kfa_pkg::ST_BOUNDS:    state_next = kfa_pkg::ST_DIV_START;
            kfa_pkg::ST_DIV_START: begin
                // Skip the divider when the progress is fixed at zero or one.
                if (span_ok && past_lo) begin
                    state_next = kfa_pkg::ST_DIV_WAIT;
                end else begin
                    state_next = kfa_pkg::ST_MUL;
                end
            end
            kfa_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    state_next = kfa_pkg::ST_MUL;
                end
            end
            kfa_pkg::ST_MUL:  state_next = kfa_pkg::ST_LERP;
            kfa_pkg::ST_LERP: state_next = kfa_pkg::ST_OUT;
            kfa_pkg::ST_OUT:  state_next = kfa_pkg::ST_IDLE;
            default:          state_next = kfa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        div_req.start = (state_reg == kfa_pkg::ST_DIV_START) && span_ok && past_lo;
        div_req.num   = now_q - lo_reg;
        div_req.den   = hi_reg - lo_reg;
    end

    // Interpolation: scalar and per-channel deltas and their magnitudes.
    logic signed [VB:0]   d_sc;
    logic [VB:0]          d_abs;
    logic signed [8:0]    d_ch [3];
    logic [8:0]           d_chabs [3];
    always_comb begin
        d_sc  = $signed({e_reg[VB-1], e_reg}) - $signed({s_reg[VB-1], s_reg});
        d_abs = d_sc[VB] ? (~d_sc + 1'b1) : d_sc;
        for (int c = 0; c < 3; c++) begin
            d_ch[c]    = $signed({1'b0, e_reg[c*8 +: 8]}) - $signed({1'b0, s_reg[c*8 +: 8]});
            d_chabs[c] = d_ch[c][8] ? (~d_ch[c] + 1'b1) : d_ch[c];
        end
    end

    logic [VB+16:0] sc_prod_reg;
    logic [VB:0]    sc_q;
    logic signed [VB+1:0] v_sc;
    logic [VB-1:0]  v_rgb;
    logic [7:0]     ch_q [3];
    always_comb begin
        sc_q = sc_prod_reg[VB+16:16];
        if (d_sc[VB]) begin
            v_sc = $signed({{2{s_reg[VB-1]}}, s_reg}) - $signed({1'b0, sc_q});
        end else begin
            v_sc = $signed({{2{s_reg[VB-1]}}, s_reg}) + $signed({1'b0, sc_q});
        end
        if (d_sc[VB]) begin
            if (v_sc < $signed({{2{e_reg[VB-1]}}, e_reg})) begin
                v_sc = $signed({{2{e_reg[VB-1]}}, e_reg});
            end
        end else if (v_sc > $signed({{2{e_reg[VB-1]}}, e_reg})) begin
            v_sc = $signed({{2{e_reg[VB-1]}}, e_reg});
        end
        v_rgb = '0;
        for (int c = 0; c < 3; c++) begin
            ch_q[c] = prod_reg[c][23:16];
            if (c*8 < VB) begin
                v_rgb[c*8 +: 8] = d_ch[c][8] ? (s_reg[c*8 +: 8] - ch_q[c])
                                             : (s_reg[c*8 +: 8] + ch_q[c]);
            end
        end
    end

    // Loop bookkeeping at the end of a tick.
    logic        whole_done;
    logic [17:0] t_sum;
    logic [15:0] cnt_inc;
    logic        finish;
    always_comb begin
        whole_done = elapsed_reg >= {1'b0, dur_reg};
        t_sum      = {1'b0, elapsed_reg} + {10'd0, tick_reg};
        cnt_inc    = (done_cnt_reg != 16'hFFFF) ? done_cnt_reg + 16'd1 : done_cnt_reg;
        finish     = whole_done && loops_reg != 16'hFFFF
                     && $signed({1'b0, cnt_inc}) >= $signed({loops_reg[15], loops_reg});
    end

    // Run state updates.
    always_comb begin
        cursor_next   = cursor_reg;
        elapsed_next  = elapsed_reg;
        done_cnt_next = done_cnt_reg;
        run_next      = run_reg;
        if (s_acc) begin
            unique case (in_mode)
                kfa_pkg::MODE_START: begin
                    run_next      = 1'b1;
                    elapsed_next  = '0;
                    done_cnt_next = '0;
                    cursor_next   = '0;
                end
                kfa_pkg::MODE_PAUSE,
                kfa_pkg::MODE_STOP: run_next = 1'b0;
                default: ;
            endcase
        end
        if (state_reg == kfa_pkg::ST_READ) begin
            cursor_next = cur_c;
        end
        if (state_reg == kfa_pkg::ST_MUL && total_reg != '0 && p_reg >= kfa_pkg::ONE_Q16
            && cursor_reg < total_reg) begin
            cursor_next = cursor_reg + CW'(1);
        end
        if (state_reg == kfa_pkg::ST_LERP) begin
            elapsed_next = t_sum[17] ? kfa_pkg::ELAPSED_MAX : t_sum[16:0];
            if (whole_done) begin
                done_cnt_next = cnt_inc;
                if (finish) begin
                    run_next = 1'b0;
                end else begin
                    elapsed_next = '0;
                    cursor_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= kfa_pkg::ST_IDLE;
            total_reg    <= '0;
            cursor_reg   <= '0;
            elapsed_reg  <= '0;
            done_cnt_reg <= '0;
            run_reg      <= 1'b0;
            dur_reg      <= '0;
            tick_reg     <= 8'd16;
            loops_reg    <= 16'd1;
            sval_reg     <= '0;
            eval_reg     <= '0;
            colour_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            elapsed_reg  <= elapsed_next;
            done_cnt_reg <= done_cnt_next;
            run_reg      <= run_next;
            if (key_we) begin
                total_reg <= total_reg + CW'(1);
            end
            // Configuration writes and the append to start value.
            if (cfg_we) begin
                unique case (cfg_addr)
                    kfa_pkg::REG_DURATION: dur_reg    <= cfg_wdata[15:0];
                    kfa_pkg::REG_TICK:     tick_reg   <= cfg_wdata[7:0];
                    kfa_pkg::REG_LOOPS:    loops_reg  <= cfg_wdata[15:0];
                    kfa_pkg::REG_START:    sval_reg   <= cfg_wdata[VB-1:0];
                    kfa_pkg::REG_END:      eval_reg   <= cfg_wdata[VB-1:0];
                    kfa_pkg::REG_COLOUR:   colour_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_acc && in_mode == kfa_pkg::MODE_APPEND && in_pct == 16'd0) begin
                sval_reg <= in_val;
            end
            // Result register: hold until taken.
            if (m_axis_tvalid && m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (s_acc && in_mode == kfa_pkg::MODE_STOP) begin
                out_valid_reg <= 1'b1;
                out_reg       <= '0;
                out_last_reg  <= 1'b1;
            end
            if (state_reg == kfa_pkg::ST_OUT) begin
                out_valid_reg <= 1'b1;
                out_reg       <= {4'd0, 4'(seg_reg), 32'(val_reg)};
                out_last_reg  <= fin_reg;
            end
        end
    end

    // Segment set-up, progress, products and the interpolated value.
    always_ff @(posedge aclk) begin
        if (state_reg == kfa_pkg::ST_READ) begin
            seg_reg <= cur_c;
        end
        if (state_reg == kfa_pkg::ST_BOUNDS) begin
            s_reg  <= sval_reg;
            e_reg  <= eval_reg;
            lo_reg <= '0;
            hi_reg <= {1'b0, dur_reg, 16'd0};
            if (total_reg != '0) begin
                if (seg_reg == '0) begin
                    e_reg  <= val_b;
                    hi_reg <= 33'(32'(pos_b) * 32'(dur_reg));
                end else if (seg_reg == total_reg) begin
                    s_reg  <= val_a;
                    lo_reg <= 33'(32'(pos_a) * 32'(dur_reg));
                end else begin
                    s_reg  <= val_a;
                    lo_reg <= 33'(32'(pos_a) * 32'(dur_reg));
                    e_reg  <= val_b;
                    hi_reg <= 33'(32'(pos_b) * 32'(dur_reg));
                end
            end
        end
        if (state_reg == kfa_pkg::ST_DIV_START) begin
            p_reg <= !span_ok ? kfa_pkg::ONE_Q16 : (!past_lo ? 17'd0 : p_reg);
        end
        if (state_reg == kfa_pkg::ST_DIV_WAIT && div_rsp.done) begin
            p_reg <= div_rsp.quot;
        end
        if (state_reg == kfa_pkg::ST_MUL) begin
            sc_prod_reg <= (VB+17)'(d_abs) * (VB+17)'(p_reg);
            for (int c = 0; c < 3; c++) begin
                prod_reg[c] <= 40'(d_chabs[c]) * 40'(p_reg);
            end
        end
        if (state_reg == kfa_pkg::ST_LERP) begin
            val_reg <= colour_reg ? v_rgb : v_sc[VB-1:0];
            fin_reg <= finish;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tlast  = out_last_reg;

    `ASSERT_IMPLY(a_no_take_busy, aclk, aresetn, state_reg != kfa_pkg::ST_IDLE, !s_axis_tready)
    `ASSERT_IMPLY(a_total_cap, aclk, aresetn, 1'b1, total_reg <= CW'(MAX_KEYS))
    `ASSERT_NEXT(a_div_follows, aclk, aresetn, div_req.start, div_rsp.busy)
    `ASSERT_IMPLY(a_div_in_wait, aclk, aresetn, div_rsp.busy,
                  state_reg == kfa_pkg::ST_DIV_WAIT)
endmodule

// ----- rtl/kfa_divider.sv -----
// Restoring serial divider: progress quotient one bit per cycle, saturated at one.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kfa_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  kfa_pkg::div_req_t req,
    output kfa_pkg::div_rsp_t rsp
);
    // Numerator is (now - lo) << 16, up to 49 bits; quotient kept to 17 bits with saturation.
    logic [48:0] num_reg, num_next;
    logic [32:0] den_reg, den_next;
    logic [33:0] rem_reg, rem_next;
    logic [16:0] quot_reg, quot_next;
    logic        sat_reg, sat_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;
    logic [33:0] shifted;

    always_comb begin
        shifted = {rem_reg[32:0], num_reg[48]};
        trial   = shifted - {1'b0, den_reg};
    end

    // Step the divider: 49 quotient bits, high ones only flag saturation.
    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            num_next  = {req.num[32:0], 16'd0};
            den_next  = req.den;
            rem_next  = '0;
            quot_next = '0;
            sat_next  = 1'b0;
            cnt_next  = 6'd49;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[47:0], 1'b0};
            if (!trial[33]) begin
                rem_next = trial;
                if (cnt_reg > 6'd17) begin
                    sat_next = 1'b1;
                end
            end else begin
                rem_next = shifted;
            end
            quot_next = {quot_reg[15:0], ~trial[33]};
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        sat_reg  <= sat_next;
    end

    always_comb begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        rsp.quot = (sat_reg || quot_reg > kfa_pkg::ONE_Q16) ? kfa_pkg::ONE_Q16 : quot_reg;
    end

    `ASSERT_NEXT(a_done_one_cycle, aclk, aresetn, rsp.done, !rsp.done)
    `ASSERT_IMPLY(a_done_not_busy, aclk, aresetn, rsp.done, !rsp.busy)
    `ASSERT_IMPLY(a_busy_counts, aclk, aresetn, rsp.busy, cnt_reg != 6'd0)
endmodule

// ----- rtl/kfa_key_store.sv -----
// Keyframe memory: position and target pairs, one write port and two registered read ports.
`timescale 1ns / 1ps
module kfa_key_store #(
    parameter int MAX_KEYS   = 8,
    parameter int VALUE_BITS = 32,
    localparam int AW        = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [15:0]           wr_pos,
    input  logic [VALUE_BITS-1:0] wr_val,
    input  logic [AW-1:0]         rd_addr_a,
    input  logic [AW-1:0]         rd_addr_b,
    output logic [15:0]           rd_pos_a,
    output logic [VALUE_BITS-1:0] rd_val_a,
    output logic [15:0]           rd_pos_b,
    output logic [VALUE_BITS-1:0] rd_val_b
);
    logic [15+VALUE_BITS:0] mem [MAX_KEYS];
    logic [15+VALUE_BITS:0] rd_a_reg;
    logic [15+VALUE_BITS:0] rd_b_reg;

    // Write one entry, read two entries through registered outputs.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_pos, wr_val};
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_pos_a = rd_a_reg[15+VALUE_BITS:VALUE_BITS];
    assign rd_val_a = rd_a_reg[VALUE_BITS-1:0];
    assign rd_pos_b = rd_b_reg[15+VALUE_BITS:VALUE_BITS];
    assign rd_val_b = rd_b_reg[VALUE_BITS-1:0];
endmodule
